// ===== src/lsd_pkg.sv =====
// Package for the load settle detector: shared constants, register
// indexes and state types. No dependencies.
package lsd_pkg;

  // Number of load-cell channels in one sample set.
  localparam int unsigned NUM_CHAN = 4;

  // Fraction bits of the emitted channel means.
  localparam int unsigned FRAC_BITS = 4;

  // Threshold register width and reset values.
  localparam int unsigned THR_W = 27;
  localparam logic [THR_W-1:0] IDLE_THR_RESET = 27'd4000;
  localparam logic [THR_W-1:0] CHG_THR_RESET  = 27'd64000;

  // Configuration register index width and register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_THR  = 8'd1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } lsd_state_e;

  // Settle mode.
  typedef enum logic {
    MODE_IDLE,
    MODE_CHANGING
  } lsd_mode_e;

endpackage

// ===== src/lsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lsd_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/load_settle_detector.sv =====
// Load settle detector top level: history RAM, running sums, settle decision
// and mean divider. Depends on lsd_pkg and lsd_ram.
//
// The block accepts one set of four load-cell samples at a time and holds
// in_stall_o high until it is back in idle: the set is taken and the oldest
// history entry is read from the single-read-port history RAM, and in the next
// cycle the running channel sums, the deviation check and the write-back of the
// new set complete. A set that settles the block then goes through the mean
// divider when HISTORY_DEPTH is not a power of two (a power of two needs only a
// shift) and loads the output register in the emit state. The mean divider
// finds sixteen quotient bits a cycle by reciprocal multiplication; the emit
// state also waits while an earlier result beat is still stalled.
// The history RAM needs no clearing pass after reset: its read data is used
// only once the history has been filled.
module load_settle_detector
  import lsd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned SAMPLE_WIDTH  = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [THR_W-1:0]               cfg_data_i,
  // Sample input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_a_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_b_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_c_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_d_sample_i,
  // Mean output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH+3:0] chan_a_mean_x16_o,
  output logic signed [SAMPLE_WIDTH+3:0] chan_b_mean_x16_o,
  output logic signed [SAMPLE_WIDTH+3:0] chan_c_mean_x16_o,
  output logic signed [SAMPLE_WIDTH+3:0] chan_d_mean_x16_o
);

  // Derived widths.
  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned LOG   = $clog2(HISTORY_DEPTH);
  localparam int unsigned AW    = LOG;
  localparam int unsigned SUMW  = SW + LOG;
  localparam int unsigned DW    = SW + 3 + LOG;
  localparam int unsigned LIMW  = THR_W + LOG;
  localparam int unsigned CW    = (DW > LIMW) ? DW : LIMW;
  localparam int unsigned OUTW  = SW + FRAC_BITS;
  localparam int unsigned UW    = SW + FRAC_BITS + LOG;
  localparam int unsigned RAMW  = NUM_CHAN * SW;
  localparam bit          IS_POW2 = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;

  // Mean divider: the dividend is split into 16-bit digits, and each digit
  // with the running remainder in front is divided by a reciprocal multiply.
  localparam int unsigned DIGW  = 16;
  localparam int unsigned NDIG  = (UW + DIGW - 1) / DIGW;
  localparam int unsigned PW    = NDIG * DIGW;
  localparam int unsigned XW    = DIGW + LOG;
  localparam int unsigned RSH   = XW + LOG;
  localparam int unsigned CNTW  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);

  localparam logic [AW-1:0]         LAST_PTR = AW'(HISTORY_DEPTH - 1);
  localparam logic signed [DW-1:0]  DEPTH_S  = DW'(HISTORY_DEPTH);
  localparam logic [CW-1:0]         DEPTH_C  = CW'(HISTORY_DEPTH);
  localparam logic [LOG:0]          DEPTH_R  = (LOG + 1)'(HISTORY_DEPTH);
  localparam logic [XW-1:0]         DEPTH_X  = XW'(HISTORY_DEPTH);
  localparam logic [XW:0]           RECIP    = (XW + 1)'(RECIP_L);
  localparam logic [CNTW-1:0]       DIV_LAST = CNTW'(NDIG - 1);
  // Offset that makes the scaled channel sum non-negative before division.
  localparam logic signed [UW:0]    BIAS     = (UW + 1)'(HISTORY_DEPTH) <<< (SW + 3);

  // Control and configuration state.
  lsd_state_e       state_q, state_d;
  lsd_mode_e        mode_q, mode_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic             full_q, full_d;
  logic [CNTW-1:0]  div_cnt_q, div_cnt_d;
  logic [THR_W-1:0] idle_thr_q;
  logic [THR_W-1:0] chg_thr_q;
  logic             out_valid_q, out_valid_d;

  // Lane registers.
  logic signed [SW-1:0]   samp_q   [NUM_CHAN];
  logic signed [SUMW-1:0] sum_q    [NUM_CHAN];
  logic signed [SUMW-1:0] sum_d    [NUM_CHAN];
  logic [PW-1:0]          div_q    [NUM_CHAN];
  logic [PW-1:0]          div_d    [NUM_CHAN];
  logic [LOG-1:0]         rem_q    [NUM_CHAN];
  logic [LOG-1:0]         rem_d    [NUM_CHAN];
  logic signed [OUTW-1:0] mean_q   [NUM_CHAN];
  logic signed [OUTW-1:0] mean_d   [NUM_CHAN];

  // Datapath nets.
  logic                   in_acc;
  logic                   out_free;
  logic                   ram_we;
  logic                   ram_re;
  logic [RAMW-1:0]        ram_wdata;
  logic [RAMW-1:0]        ram_rdata;
  logic signed [DW-1:0]   total;
  logic signed [DW-1:0]   scaled_total;
  logic signed [DW-1:0]   sum_all;
  logic signed [DW-1:0]   diff;
  logic [DW-1:0]          mag;
  logic [CW-1:0]          mag_c;
  logic [CW-1:0]          idle_lim;
  logic [CW-1:0]          chg_lim;
  logic                   settle;

  assign in_acc      = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_thr_q <= IDLE_THR_RESET;
      chg_thr_q  <= CHG_THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IDLE_THR: idle_thr_q <= cfg_data_i;
        CFG_CHG_THR:  chg_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the sample set of an accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q[0] <= chan_a_sample_i;
      samp_q[1] <= chan_b_sample_i;
      samp_q[2] <= chan_c_sample_i;
      samp_q[3] <= chan_d_sample_i;
    end
  end

  // History RAM: the oldest entry is read at accept and overwritten in the next
  // cycle, so the read and the write of one entry never overlap.
  assign ram_re    = in_acc;
  assign ram_we    = (state_q == ST_UPDATE);
  assign ram_wdata = {samp_q[3], samp_q[2], samp_q[1], samp_q[0]};

  lsd_ram #(
    .WIDTH (RAMW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Deviation of the new total from the history mean, scaled by the depth.
  always_comb begin
    total   = '0;
    sum_all = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      total   = total + DW'(samp_q[c]);
      sum_all = sum_all + DW'(sum_q[c]);
    end
    scaled_total = DW'(total * DEPTH_S);
    diff         = full_q ? (scaled_total - sum_all) : '0;
    mag          = diff[DW-1] ? DW'(-diff) : DW'(diff);
    mag_c        = CW'(mag);
    idle_lim     = CW'(CW'(idle_thr_q) * DEPTH_C);
    chg_lim      = CW'(CW'(chg_thr_q) * DEPTH_C);
    settle       = (mode_q == MODE_CHANGING) && (mag_c < idle_lim);
  end

  // Per-channel running sums, divider and output lanes.
  always_comb begin
    logic signed [SW-1:0] old_samp;
    logic signed [UW:0]   u_s;
    logic [XW-1:0]        dig_x;
    logic [2*XW:0]        dig_p;
    logic [DIGW-1:0]      dig_q;
    for (int c = 0; c < NUM_CHAN; c++) begin
      old_samp = ram_rdata[c*SW +: SW];
      sum_d[c] = sum_q[c] + SUMW'(samp_q[c]) - (full_q ? SUMW'(old_samp) : '0);
      u_s      = ((UW + 1)'(sum_d[c]) <<< FRAC_BITS) + BIAS;
      dig_x    = {rem_q[c], div_q[c][PW-1 -: DIGW]};
      dig_p    = {{(XW + 1){1'b0}}, dig_x} * {{XW{1'b0}}, RECIP};
      dig_q    = dig_p[RSH +: DIGW];
      div_d[c] = div_q[c];
      rem_d[c] = rem_q[c];
      mean_d[c] = {~div_q[c][OUTW-1], div_q[c][OUTW-2:0]};
      case (state_q)
        ST_UPDATE: begin
          div_d[c] = IS_POW2 ? PW'(u_s[UW-1:0] >> LOG) : PW'(u_s[UW-1:0]);
          rem_d[c] = '0;
        end
        ST_DIVIDE: begin
          // One 16-bit quotient digit per cycle; the remainder is what the
          // digit times the depth leaves over.
          div_d[c] = (div_q[c] << DIGW) | PW'(dig_q);
          rem_d[c] = LOG'(dig_x - {{LOG{1'b0}}, dig_q} * DEPTH_X);
        end
        default: ;
      endcase
    end
  end

  // Lane registers: running sums reset, the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        sum_q[c] <= '0;
      end
    end else if (state_q == ST_UPDATE) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        sum_q[c] <= sum_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      div_q[c] <= div_d[c];
      rem_q[c] <= rem_d[c];
      if (state_q == ST_EMIT && out_free) begin
        mean_q[c] <= mean_d[c];
      end
    end
  end

  // Sequencer: next state, history pointer and settle mode.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    ptr_d       = ptr_q;
    full_d      = full_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ptr_d     = (ptr_q == LAST_PTR) ? '0 : ptr_q + 1'b1;
        full_d    = full_q || (ptr_q == LAST_PTR);
        div_cnt_d = '0;
        if (settle) begin
          mode_d  = MODE_IDLE;
          state_d = IS_POW2 ? ST_EMIT : ST_DIVIDE;
        end else begin
          if (mode_q == MODE_IDLE && mag_c > chg_lim) begin
            mode_d = MODE_CHANGING;
          end
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_IDLE;
      ptr_q       <= '0;
      full_q      <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      ptr_q       <= ptr_d;
      full_q      <= full_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output ports.
  assign out_valid_o       = out_valid_q;
  assign chan_a_mean_x16_o = mean_q[0];
  assign chan_b_mean_x16_o = mean_q[1];
  assign chan_c_mean_x16_o = mean_q[2];
  assign chan_d_mean_x16_o = mean_q[3];

  // Once the history is full it stays full.
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("history full flag dropped");

  // The block cannot be changing before the history has filled.
  a_mode_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_q |-> mode_q == MODE_IDLE)
    else $error("changing mode with partial history");

  // A settling set returns the block to idle mode.
  a_settle_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && settle) |=> mode_q == MODE_IDLE)
    else $error("settle did not clear changing mode");

  // A new result beat is only raised from the emit state.
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit state");

  // The divider remainder stays below the depth.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIVIDE |-> (LOG + 1)'(rem_q[0]) < DEPTH_R)
    else $error("divider remainder out of range");

endmodule

// ===== bench/lsd_checker.sv =====
// Checker for the load settle detector: follows the configuration, sample and
// mean channels, predicts every mean beat and compares it field by field.
// Depends on lsd_pkg.
module lsd_checker
  import lsd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned SAMPLE_WIDTH  = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [THR_W-1:0]               cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_a_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_b_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_c_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] chan_d_sample_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic signed [SAMPLE_WIDTH+3:0] chan_a_mean_x16_i,
  input  logic signed [SAMPLE_WIDTH+3:0] chan_b_mean_x16_i,
  input  logic signed [SAMPLE_WIDTH+3:0] chan_c_mean_x16_i,
  input  logic signed [SAMPLE_WIDTH+3:0] chan_d_mean_x16_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  localparam int unsigned MEAN_W = SAMPLE_WIDTH + 4;
  localparam longint DEPTH = longint'(HISTORY_DEPTH);
  localparam longint MEAN_MAX = (64'sd1 <<< (MEAN_W - 1)) - 64'sd1;
  localparam longint MEAN_MIN = -(64'sd1 <<< (MEAN_W - 1));

  // One set of channel means, as carried by one result beat.
  typedef struct packed {
    logic [MEAN_W-1:0] a;
    logic [MEAN_W-1:0] b;
    logic [MEAN_W-1:0] c;
    logic [MEAN_W-1:0] d;
  } chan_means_t;

  // Predicted state of the block.
  longint            hist_set [HISTORY_DEPTH][NUM_CHAN];
  int unsigned       sets_held;
  lsd_mode_e         mode;
  logic [THR_W-1:0]  idle_thr;
  logic [THR_W-1:0]  chg_thr;

  // Channel means still owed by the block, oldest first.
  chan_means_t       mean_queue [$];
  chan_means_t       want;

  // Takes one accepted sample set into the history and queues the channel
  // means when the set settles a change.
  function automatic void absorb_set(input longint a, input longint b,
                                     input longint c, input longint d);
    longint      smp [NUM_CHAN];
    longint      total;
    longint      hist_sum;
    longint      dev16;
    longint      mag;
    longint      acc;
    longint      scaled;
    longint      m [NUM_CHAN];
    chan_means_t res;
    smp[0] = a;
    smp[1] = b;
    smp[2] = c;
    smp[3] = d;
    total = 0;
    for (int ch = 0; ch < NUM_CHAN; ch++) total += smp[ch];

    // The deviation uses the history as it stood before this set.
    dev16 = 0;
    if (sets_held >= HISTORY_DEPTH) begin
      hist_sum = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        for (int ch = 0; ch < NUM_CHAN; ch++) hist_sum += hist_set[i][ch];
      end
      dev16 = DEPTH * total - hist_sum;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        for (int ch = 0; ch < NUM_CHAN; ch++) hist_set[i][ch] = hist_set[i+1][ch];
      end
      for (int ch = 0; ch < NUM_CHAN; ch++) hist_set[HISTORY_DEPTH-1][ch] = smp[ch];
    end else begin
      for (int ch = 0; ch < NUM_CHAN; ch++) hist_set[sets_held][ch] = smp[ch];
      sets_held++;
    end

    // Strict comparisons against the scaled thresholds.
    mag = (dev16 < 0) ? -dev16 : dev16;
    if (mode == MODE_CHANGING && mag < DEPTH * longint'(idle_thr)) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        acc = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++) acc += hist_set[i][ch];
        scaled = acc * 16;
        m[ch] = scaled / DEPTH;
        if ((scaled % DEPTH) != 0 && scaled < 0) m[ch] = m[ch] - 1;
        if (m[ch] > MEAN_MAX) m[ch] = MEAN_MAX;
        if (m[ch] < MEAN_MIN) m[ch] = MEAN_MIN;
      end
      res.a = m[0][MEAN_W-1:0];
      res.b = m[1][MEAN_W-1:0];
      res.c = m[2][MEAN_W-1:0];
      res.d = m[3][MEAN_W-1:0];
      mean_queue.push_back(res);
      mode = MODE_IDLE;
    end else if (mode == MODE_IDLE && mag > DEPTH * longint'(chg_thr)) begin
      mode = MODE_CHANGING;
    end
  endfunction

  function automatic void check_mean(input string chan, input logic [MEAN_W-1:0] exp_val,
                                     input logic [MEAN_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mean_x16 expected %0d, got %0d", $time, chan,
               $signed(exp_val), $signed(act_val));
      fail_count_o++;
    end
  endfunction

  // Outputs of the block are sampled on the rising edge; beats of each channel
  // are handled in the order mean, register write, sample set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_queue.delete();
      sets_held    = 0;
      mode         = MODE_IDLE;
      idle_thr     = IDLE_THR_RESET;
      chg_thr      = CHG_THR_RESET;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (mean_queue.size() == 0) begin
          $display("%0t: mean beat with nothing expected, got %0d %0d %0d %0d", $time,
                   chan_a_mean_x16_i, chan_b_mean_x16_i, chan_c_mean_x16_i,
                   chan_d_mean_x16_i);
          fail_count_o++;
        end else begin
          // Take the oldest owed set of means off the queue.
          want = mean_queue[0];
          mean_queue.delete(0);
          check_mean("chan_a", want.a, chan_a_mean_x16_i);
          check_mean("chan_b", want.b, chan_b_mean_x16_i);
          check_mean("chan_c", want.c, chan_c_mean_x16_i);
          check_mean("chan_d", want.d, chan_d_mean_x16_i);
        end
      end

      // Writes to unknown indexes leave both thresholds alone.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IDLE_THR: idle_thr = cfg_data_i;
          CFG_CHG_THR:  chg_thr  = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        absorb_set(chan_a_sample_i, chan_b_sample_i, chan_c_sample_i, chan_d_sample_i);
      end
      pending_o = mean_queue.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the load settle detector: clock, reset, sample and register
// stimulus, output stalls and the verdict. Depends on lsd_pkg,
// load_settle_detector and lsd_checker.
module tb;
  import lsd_pkg::*;

  localparam int unsigned HISTORY_DEPTH = 16;
  localparam int unsigned SAMPLE_WIDTH  = 24;
  localparam int unsigned MEAN_W        = SAMPLE_WIDTH + 4;
  localparam longint SMP_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam longint SMP_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam logic [THR_W-1:0] THR_MAX = '1;
  // Quiet cycles before a register write and at the end; covers the slowest
  // mean divider the parameters allow.
  localparam int SETTLE_CYCLES = 40;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [THR_W-1:0]               cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] chan_a;
  logic signed [SAMPLE_WIDTH-1:0] chan_b;
  logic signed [SAMPLE_WIDTH-1:0] chan_c;
  logic signed [SAMPLE_WIDTH-1:0] chan_d;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [MEAN_W-1:0]       mean_a;
  logic signed [MEAN_W-1:0]       mean_b;
  logic signed [MEAN_W-1:0]       mean_c;
  logic signed [MEAN_W-1:0]       mean_d;
  int                             fail_count;
  int                             pending;

  // Stimulus bookkeeping.
  int unsigned      sets_sent = 0;
  bit               steady = 1'b0;
  int unsigned      out_hold = 0;
  longint           level [NUM_CHAN];
  logic [THR_W-1:0] cur_chg = CHG_THR_RESET;

  always #5 clk = ~clk;

  load_settle_detector #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .chan_a_sample_i  (chan_a),
    .chan_b_sample_i  (chan_b),
    .chan_c_sample_i  (chan_c),
    .chan_d_sample_i  (chan_d),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .chan_a_mean_x16_o(mean_a),
    .chan_b_mean_x16_o(mean_b),
    .chan_c_mean_x16_o(mean_c),
    .chan_d_mean_x16_o(mean_d)
  );

  lsd_checker #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .chan_a_sample_i  (chan_a),
    .chan_b_sample_i  (chan_b),
    .chan_c_sample_i  (chan_c),
    .chan_d_sample_i  (chan_d),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .chan_a_mean_x16_i(mean_a),
    .chan_b_mean_x16_i(mean_b),
    .chan_c_mean_x16_i(mean_c),
    .chan_d_mean_x16_i(mean_d),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Each mean beat draws how long the next one is held off.
  always @(posedge clk) begin
    if (out_valid && !out_stall) out_hold = steady ? 0 : $urandom_range(0, 3);
  end

  always @(negedge clk) begin
    if (out_valid && out_hold != 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sends one sample set after a random gap (none in steady runs) and returns at
  // the falling edge after the beat was taken.
  task automatic send_set(input longint a, input longint b, input longint c,
                          input longint d);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    chan_a   <= a[SAMPLE_WIDTH-1:0];
    chan_b   <= b[SAMPLE_WIDTH-1:0];
    chan_c   <= c[SAMPLE_WIDTH-1:0];
    chan_d   <= d[SAMPLE_WIDTH-1:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sets_sent++;
  endtask

  // Stops the samples and waits until every owed mean has arrived and the
  // block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves the valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes both thresholds, with a stray write to an unknown index between.
  task automatic set_thresholds(input logic [THR_W-1:0] idle_val,
                                input logic [THR_W-1:0] chg_val);
    logic [31:0] junk;
    junk = $urandom();
    drain();
    write_reg(CFG_IDLE_THR, idle_val);
    write_reg(CFG_CHG_THR + 8'd1 + CFG_IDX_W'($urandom_range(0, 253)), junk[THR_W-1:0]);
    write_reg(CFG_CHG_THR, chg_val);
    cfg_valid <= 1'b0;
    cur_chg = chg_val;
  endtask

  function automatic longint any_sample();
    logic [31:0]                    u;
    logic signed [SAMPLE_WIDTH-1:0] r;
    u = $urandom();
    r = u[SAMPLE_WIDTH-1:0];
    return longint'(r);
  endfunction

  function automatic longint near(input longint base, input int unsigned amp);
    longint v;
    v = base + longint'($urandom_range(0, 2 * amp)) - longint'(amp);
    if (v > SMP_MAX) v = SMP_MAX;
    if (v < SMP_MIN) v = SMP_MIN;
    return v;
  endfunction

  // A load held on the cells: every set is the channel levels plus noise.
  task automatic run_event(input int unsigned len, input int unsigned amp);
    for (int unsigned i = 0; i < len; i++) begin
      send_set(near(level[0], amp), near(level[1], amp), near(level[2], amp),
               near(level[3], amp));
    end
  endtask

  // Mostly settling events with random levels; the rest are drifts, cut-short
  // events and raw noise.
  task automatic random_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned amp;
    int unsigned drift;
    bit          rail;
    stop_at = sets_sent + quota;
    while (sets_sent < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: amp = 0;
        1: amp = 3;
        2: amp = 60;
        default: amp = 400;
      endcase
      rail = ($urandom_range(0, 7) == 0);
      if (pick <= 5 || pick == 7) begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          if (rail) level[ch] = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
          else      level[ch] = any_sample();
        end
        run_event(pick == 7 ? $urandom_range(2, 10) : $urandom_range(17, 40), amp);
      end else if (pick == 6) begin
        // Small shifts around the change limit.
        drift = (cur_chg / 2 > 27'd1048576) ? 1048576 : int'(cur_chg / 2);
        for (int ch = 0; ch < NUM_CHAN; ch++) level[ch] = near(level[ch], drift);
        run_event($urandom_range(17, 30), amp);
      end else begin
        repeat ($urandom_range(1, 6)) send_set(any_sample(), any_sample(), any_sample(),
                                               any_sample());
      end
    end
  endtask

  // Run limit.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [THR_W-1:0] idle_pick;
    logic [THR_W-1:0] chg_pick;
    int unsigned      quota;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    chan_a    = '0;
    chan_b    = '0;
    chan_c    = '0;
    chan_d    = '0;
    out_stall = 1'b0;
    for (int ch = 0; ch < NUM_CHAN; ch++) level[ch] = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the history with rail-to-rail sets that total zero; no change can
    // start while it fills.
    set_thresholds(27'd1000, CHG_THR_RESET);
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (i % 2 == 0) send_set(SMP_MAX, SMP_MIN, 1, 0);
      else            send_set(SMP_MIN, SMP_MAX, 0, 1);
    end
    // Deviation exactly at the change limit, then just over it; next exactly at
    // the settle limit, then well inside it.
    send_set(16000, 16000, 16000, 16000);
    send_set(17004, 17004, 17004, 17004);
    send_set(2313, 2313, 2313, 2312);
    send_set(2208, 2207, 2207, 2207);

    // Any deviation starts a change and any change settles at once.
    set_thresholds(THR_MAX, '0);
    send_set(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    send_set(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);

    // Random phases over a spread of threshold settings.
    for (int p = 0; p < 8; p++) begin
      quota = 300;
      case (p)
        0: begin idle_pick = IDLE_THR_RESET; chg_pick = CHG_THR_RESET; end
        1: begin idle_pick = 27'd12000;      chg_pick = 27'd30000;     end
        2: begin idle_pick = '0;             chg_pick = CHG_THR_RESET; quota = 120; end
        3: begin idle_pick = THR_MAX;        chg_pick = THR_MAX;       quota = 120; end
        4: begin idle_pick = THR_MAX;        chg_pick = '0;            end
        5: begin idle_pick = '0;             chg_pick = '0;            quota = 120; end
        default: begin
          idle_pick = THR_W'($urandom_range(2000, 50000));
          chg_pick  = THR_W'($urandom_range(int'(idle_pick), 4000000));
        end
      endcase
      set_thresholds(idle_pick, chg_pick);
      random_phase(quota);
    end

    steady = 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lsd_pkg.sv
src/lsd_ram.sv
src/load_settle_detector.sv
bench/lsd_checker.sv
bench/tb.sv
